// ===== src/esd_pkg.sv =====
package esd_pkg;

  // decoder mode codes
  localparam logic [2:0] ModeNormal  = 3'd0;
  localparam logic [2:0] ModeEscape  = 3'd1;
  localparam logic [2:0] ModeOctOne  = 3'd2;
  localparam logic [2:0] ModeOctTwo  = 3'd3;
  localparam logic [2:0] ModeHexZero = 3'd4;
  localparam logic [2:0] ModeHexOne  = 3'd5;
  localparam logic [2:0] ModeDiscard = 3'd6;

  // result status codes
  localparam logic [1:0] StByte = 2'd0;
  localparam logic [1:0] StOk   = 2'd1;
  localparam logic [1:0] StBad  = 2'd2;

  // characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChDquot = 8'h22;
  localparam logic [7:0] ChSquot = 8'h27;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowV  = 8'h76;
  localparam logic [7:0] ChLowX  = 8'h78;

  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic       last;
    logic [1:0] status;
    logic [7:0] data;
  } res_t;

  typedef res_t [MaxRes-1:0] res_vec_t;

  // one decode step: results plus the state it leaves behind
  typedef struct packed {
    logic [1:0] cnt;
    res_vec_t   res;
    logic [2:0] mode;
    logic [7:0] acc;
  } dec_t;

  function automatic logic is_octal(input logic [7:0] b);
    return b[7:3] == 5'b00110;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] h;
    h = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) h = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      h = {1'b0, b[3:0] + 4'd9};
    return h;
  endfunction

endpackage

// ===== src/escape_sequence_decoder.sv =====
// Path: a request sits in the input register until the result register has room
//   for all its results; its results are then loaded into the result register.
// Throughput: one byte per cycle while each byte gives at most one result and the
//   receiver is ready; a byte giving up to 3 results holds the next decode until
//   its final result leaves, one per ready cycle; a stalled receiver stalls input.
// Reset: asynchronous, active low; clears mode, digit accumulator and valid flags.
module escape_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  // result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] status
  output logic       m_axis_tlast_o    // last_of_run
);
  import esd_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // decoder state
  logic [2:0] mode_q, mode_d;
  logic [7:0] acc_q, acc_d;

  dec_t dec;
  res_t head;
  logic buf_can_load;
  logic dec_fire;

  // the request in the input register is decoded once the result register
  // has room for all its results
  assign dec_fire        = in_valid_q && buf_can_load;
  assign s_axis_tready_o = !in_valid_q || dec_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  esd_decode u_decode (
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .mode_i (mode_q),
    .acc_i  (acc_q),
    .dec_o  (dec)
  );

  // state advances only when a request is actually decoded
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    if (dec_fire) begin
      mode_d = dec.mode;
      acc_d  = dec.acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      acc_q  <= 8'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

  // result register: up to three results, drained one per cycle while the receiver is ready
  esd_result_buf u_result_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (dec_fire),
    .load_cnt_i (dec.cnt),
    .load_res_i (dec.res),
    .can_load_o (buf_can_load),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .head_o     (head)
  );

  assign m_axis_tdata_o = head.data;
  assign m_axis_tuser_o = head.status;
  assign m_axis_tlast_o = head.last;

endmodule

// ===== src/esd_decode.sv =====
module esd_decode (
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  acc_i,
  output esd_pkg::dec_t dec_o
);
  import esd_pkg::*;

  logic [1:0] n;
  res_vec_t   res;
  logic [2:0] m;
  logic [7:0] acc;
  logic       consumed;
  logic       err;
  logic [4:0] h;

  always_comb begin
    n        = 2'd0;
    res      = '0;
    m        = mode_i;
    acc      = acc_i;
    consumed = 1'b0;
    err      = 1'b0;
    h        = hex_value(byte_i);

    if (mode_i == ModeDiscard) begin
      if (last_i) begin
        m   = ModeNormal;
        acc = '0;
      end
    end else begin
      // pending octal run: extend it or flush it
      if (m == ModeOctOne || m == ModeOctTwo) begin
        if (is_octal(byte_i)) begin
          if (m == ModeOctOne) begin
            acc = {acc[4:0], byte_i[2:0]};
            m   = ModeOctTwo;
          end else begin
            res[n] = '{last: 1'b0, status: StByte, data: {acc[4:0], byte_i[2:0]}};
            n      = n + 2'd1;
            acc    = '0;
            m      = ModeNormal;
          end
          consumed = 1'b1;
        end else begin
          res[n] = '{last: 1'b0, status: StByte, data: acc};
          n      = n + 2'd1;
          acc    = '0;
          m      = ModeNormal;
        end
      end

      if (!consumed) begin
        case (m)
          ModeEscape: begin
            m = ModeNormal;
            case (byte_i)
              ChLf: ;
              ChBsl: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChBsl}; n = n + 2'd1;
              end
              ChSquot: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChSquot}; n = n + 2'd1;
              end
              ChDquot: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChDquot}; n = n + 2'd1;
              end
              ChLowB: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChBs}; n = n + 2'd1;
              end
              ChLowF: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChFf}; n = n + 2'd1;
              end
              ChLowT: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChTab}; n = n + 2'd1;
              end
              ChLowN: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChLf}; n = n + 2'd1;
              end
              ChLowR: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChCr}; n = n + 2'd1;
              end
              ChLowV: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChVt}; n = n + 2'd1;
              end
              ChLowA: begin
                res[n] = '{last: 1'b0, status: StByte, data: ChBel}; n = n + 2'd1;
              end
              ChLowX: begin
                acc = '0;
                m   = ModeHexZero;
              end
              default: begin
                if (is_octal(byte_i)) begin
                  acc = {5'd0, byte_i[2:0]};
                  m   = ModeOctOne;
                end else begin
                  err = 1'b1;
                end
              end
            endcase
          end
          ModeHexZero: begin
            if (!h[4]) begin
              acc = {4'd0, h[3:0]};
              m   = ModeHexOne;
            end else begin
              err = 1'b1;
            end
          end
          ModeHexOne: begin
            if (!h[4]) begin
              res[n] = '{last: 1'b0, status: StByte, data: {acc[3:0], h[3:0]}};
              n      = n + 2'd1;
              acc    = '0;
              m      = ModeNormal;
            end else begin
              err = 1'b1;
            end
          end
          default: begin
            // normal text, also the unused mode code
            m = ModeNormal;
            if (byte_i == ChBsl) begin
              m = ModeEscape;
            end else begin
              res[n] = '{last: 1'b0, status: StByte, data: byte_i};
              n      = n + 2'd1;
            end
          end
        endcase
      end

      if (err) begin
        res[n] = '{last: 1'b0, status: StBad, data: ChNul};
        n      = n + 2'd1;
        m      = last_i ? ModeNormal : ModeDiscard;
        acc    = '0;
      end else if (last_i) begin
        if (m == ModeNormal) begin
          res[n] = '{last: 1'b0, status: StOk, data: ChNul};
          n      = n + 2'd1;
        end else if (m == ModeOctOne || m == ModeOctTwo) begin
          res[n] = '{last: 1'b0, status: StByte, data: acc};
          n      = n + 2'd1;
          res[n] = '{last: 1'b0, status: StOk, data: ChNul};
          n      = n + 2'd1;
        end else begin
          res[n] = '{last: 1'b0, status: StBad, data: ChNul};
          n      = n + 2'd1;
        end
        m   = ModeNormal;
        acc = '0;
      end
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;

    dec_o.cnt  = n;
    dec_o.res  = res;
    dec_o.mode = m;
    dec_o.acc  = acc;
  end

endmodule

// ===== src/esd_result_buf.sv =====
module esd_result_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [1:0]        load_cnt_i,
  input  esd_pkg::res_vec_t load_res_i,
  output logic              can_load_o,
  output logic              valid_o,
  input  logic              ready_i,
  output esd_pkg::res_t     head_o
);
  import esd_pkg::*;

  res_vec_t   slots_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o    = cnt_q != 2'd0;
  assign pop        = valid_o && ready_i;
  // room when empty, or once the final waiting result leaves this cycle
  assign can_load_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);
  assign head_o     = slots_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= load_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slots_q <= load_res_i;
    end else if (pop) begin
      slots_q[0] <= slots_q[1];
      slots_q[1] <= slots_q[2];
    end
  end

endmodule
